[hdl/seh_pkg.sv]
// shared types and constants for steering end-stop homing
package seh_pkg;

    // field widths
    localparam int unsigned POS_W    = 32;
    localparam int unsigned ABS_W    = 16;
    localparam int unsigned STEP_W   = 20;
    localparam int unsigned THR_W    = 31;
    localparam int unsigned WIN_W    = 20;
    localparam int unsigned MAX_RES  = 3;
    localparam int unsigned RIDX_W   = 2;
    localparam int unsigned IN_DATA_W  = 80;
    localparam int unsigned OUT_DATA_W = 104;
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    // operation codes
    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // register indexes
    localparam logic [1:0] REG_STEP_INCREMENT   = 2'd0;
    localparam logic [1:0] REG_TORQUE_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_CENTER_WINDOW    = 2'd2;

    // reset values of the registers
    localparam logic [STEP_W-1:0] STEP_RESET = 20'd4096;
    localparam logic [THR_W-1:0]  THR_RESET  = 31'd1000;
    localparam logic [WIN_W-1:0]  WIN_RESET  = 20'd100;

    typedef enum logic [1:0] {
        PH_SEEK_MIN = 2'd0,
        PH_SEEK_MAX = 2'd1,
        PH_DONE     = 2'd2
    } seh_phase_t;

    typedef struct packed {
        logic [STEP_W-1:0] step_increment;
        logic [THR_W-1:0]  torque_threshold;
        logic [WIN_W-1:0]  center_window;
    } seh_cfg_t;

    typedef struct packed {
        logic                    operation;
        logic signed [POS_W-1:0] encoder_position;
        logic signed [POS_W-1:0] motor_torque;
        logic [ABS_W-1:0]        absolute_angle;
    } seh_in_t;

    typedef struct packed {
        logic [POS_W-1:0]        target_position;
        seh_phase_t              seek_phase;
        logic                    min_found;
        logic                    max_found;
        logic signed [POS_W-1:0] min_position;
        logic signed [POS_W-1:0] max_position;
        logic [ABS_W-1:0]        min_absolute;
        logic [ABS_W-1:0]        max_absolute;
    } seh_state_t;

    // all results of one item
    typedef struct packed {
        logic                              has_command;
        logic [RIDX_W-1:0]                 last_index;
        logic [MAX_RES-1:0][POS_W-1:0]     targets;
        logic                              at_center;
        logic signed [POS_W-1:0]           center_position;
    } seh_result_t;

endpackage

[hdl/steering_end_stop_homing_top.sv]
// Steering end-stop homing: one axis driven against its stops, then to the midpoint.
// An item is taken into an input register, its whole step is worked out
// combinationally and its one to three results go into a result buffer that drains
// one result per cycle while m_axis_tready is high, so single-result items flow at
// one per cycle unless the output stalls; an item with more results holds the output
// side until all are taken, the next item waits in the input register and the input
// stalls. An item passes the input register, then the result buffer, before its first
// result is presented. The user must write the three registers over the APB port at
// byte addresses 0, 4 and 8 only while no item is in flight; the block does not enforce this.
module steering_end_stop_homing_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // encoder_position [31:0], motor_torque [63:32], absolute_angle [79:64]
    input  logic [seh_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // operation [0]
    input  logic                              s_axis_tuser,
    // result items
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // command_target [31:0], at_center [32], center_position [64:33],
    // min_absolute [80:65], max_absolute [96:81], zero [103:97]
    output logic [seh_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // command_valid [0]
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [seh_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [seh_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [seh_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import seh_pkg::*;

    seh_cfg_t                      cfg_reg;
    seh_state_t                    state_reg;
    seh_state_t                    state_next;
    seh_in_t                       in_reg;
    logic                          in_valid_reg;
    seh_result_t                   step_res;
    logic                          out_valid_reg;
    logic                          cmd_valid_reg;
    logic [RIDX_W-1:0]             idx_reg;
    logic [RIDX_W-1:0]             last_reg;
    logic [MAX_RES-1:0][POS_W-1:0] tgt_reg;
    logic                          at_center_reg;
    logic signed [POS_W-1:0]       center_reg;
    logic [ABS_W-1:0]              min_abs_reg;
    logic [ABS_W-1:0]              max_abs_reg;
    logic [POS_W-1:0]              cur_target;
    logic                          out_last;
    logic                          buf_free;
    logic                          advance;
    logic                          cfg_write;

    // handshake control
    assign out_last      = (idx_reg == last_reg);
    assign buf_free      = !out_valid_reg || (m_axis_tready && out_last);
    assign advance       = in_valid_reg && buf_free;
    assign s_axis_tready = !in_valid_reg || advance;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_increment   <= STEP_RESET;
            cfg_reg.torque_threshold <= THR_RESET;
            cfg_reg.center_window    <= WIN_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_STEP_INCREMENT:   cfg_reg.step_increment   <= pwdata[STEP_W-1:0];
                REG_TORQUE_THRESHOLD: cfg_reg.torque_threshold <= pwdata[THR_W-1:0];
                REG_CENTER_WINDOW:    cfg_reg.center_window    <= pwdata[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (paddr[3:2])
            REG_STEP_INCREMENT:
                prdata = {{(APB_DATA_W-STEP_W){1'b0}}, cfg_reg.step_increment};
            REG_TORQUE_THRESHOLD:
                prdata = {{(APB_DATA_W-THR_W){1'b0}}, cfg_reg.torque_threshold};
            REG_CENTER_WINDOW:
                prdata = {{(APB_DATA_W-WIN_W){1'b0}}, cfg_reg.center_window};
            default:
                prdata = '0;
        endcase
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_reg.operation        <= s_axis_tuser;
            in_reg.encoder_position <= s_axis_tdata[31:0];
            in_reg.motor_torque     <= s_axis_tdata[63:32];
            in_reg.absolute_angle   <= s_axis_tdata[79:64];
        end
    end

    // homing step
    seh_step u_step (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .item (in_reg),
        .nxt  (state_next),
        .res  (step_res)
    );

    // homing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.target_position <= '0;
            state_reg.seek_phase      <= PH_SEEK_MIN;
            state_reg.min_found       <= 1'b0;
            state_reg.max_found       <= 1'b0;
            state_reg.min_position    <= '0;
            state_reg.max_position    <= '0;
            state_reg.min_absolute    <= '0;
            state_reg.max_absolute    <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            last_reg      <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
            idx_reg       <= '0;
            last_reg      <= step_res.last_index;
        end
        else if (out_valid_reg && m_axis_tready)
        begin
            if (out_last)
                out_valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 1'b1;
        end
    end

    // result buffer payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cmd_valid_reg <= step_res.has_command;
            tgt_reg       <= step_res.targets;
            at_center_reg <= step_res.at_center;
            center_reg    <= step_res.center_position;
            min_abs_reg   <= state_next.min_absolute;
            max_abs_reg   <= state_next.max_absolute;
        end
    end

    // select the current result
    always_comb
    begin
        case (idx_reg)
            2'd0:    cur_target = tgt_reg[0];
            2'd1:    cur_target = tgt_reg[1];
            2'd2:    cur_target = tgt_reg[2];
            default: cur_target = '0;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last;
    assign m_axis_tuser  = cmd_valid_reg;
    assign m_axis_tdata  = {7'b0, max_abs_reg, min_abs_reg, center_reg, at_center_reg,
                            cur_target};

endmodule

[hdl/seh_step.sv]
// combinational homing step: next state and the result list for one item
module seh_step (
    input  seh_pkg::seh_cfg_t    cfg,
    input  seh_pkg::seh_state_t  cur,
    input  seh_pkg::seh_in_t     item,
    output seh_pkg::seh_state_t  nxt,
    output seh_pkg::seh_result_t res
);
    import seh_pkg::*;

    logic [POS_W-1:0]        inc;
    logic [POS_W-1:0]        stepped;
    logic                    torque_hit;
    logic                    enc_nonneg;
    logic                    enc_pos;
    logic                    f_sample;
    logic                    f_min;
    logic                    f_max;
    logic [POS_W-1:0]        v_sample;
    logic [POS_W-1:0]        v_min;
    logic [POS_W-1:0]        v_max;
    logic signed [POS_W:0]   sum;
    logic signed [POS_W:0]   sum_adj;
    logic signed [POS_W-1:0] mid;
    logic signed [POS_W:0]   diff;
    logic [POS_W:0]          abs_diff;
    logic [1:0]              n_cmd;

    always_comb
    begin
        nxt = cur;
        inc = '0;
        stepped = cur.target_position;
        f_sample = 1'b0;
        f_min = 1'b0;
        f_max = 1'b0;
        v_sample = '0;
        v_min = {{(POS_W-STEP_W){1'b0}}, cfg.step_increment};
        enc_nonneg = ~item.encoder_position[POS_W-1];
        enc_pos = enc_nonneg && (item.encoder_position != '0);
        torque_hit = ~item.motor_torque[POS_W-1]
                     && (item.motor_torque[THR_W-1:0] > cfg.torque_threshold);

        if (item.operation == OP_START)
        begin
            nxt.target_position = item.encoder_position;
            nxt.seek_phase = PH_SEEK_MIN;
            nxt.min_found = 1'b0;
            nxt.max_found = 1'b0;
        end
        else
        begin
            // phase increment
            case (cur.seek_phase)
                PH_SEEK_MIN: inc = '0 - {{(POS_W-STEP_W){1'b0}}, cfg.step_increment};
                PH_SEEK_MAX: inc = {{(POS_W-STEP_W){1'b0}}, cfg.step_increment};
                default:     inc = '0;
            endcase
            if (!cur.min_found || enc_nonneg)
                stepped = cur.target_position + inc;
            nxt.target_position = stepped;
            f_sample = !cur.min_found || !cur.max_found;
            v_sample = stepped;

            // minimum stop
            if (torque_hit && cur.seek_phase == PH_SEEK_MIN && !cur.min_found)
            begin
                f_min = 1'b1;
                nxt.min_position = item.encoder_position;
                nxt.min_absolute = item.absolute_angle;
                nxt.min_found = 1'b1;
                nxt.seek_phase = PH_SEEK_MAX;
                nxt.target_position = v_min;
            end

            // maximum stop, seen after a possible minimum on the same item
            if (torque_hit && nxt.seek_phase == PH_SEEK_MAX && !cur.max_found && enc_pos)
            begin
                f_max = 1'b1;
                nxt.max_position = item.encoder_position;
                nxt.max_absolute = item.absolute_angle;
                nxt.max_found = 1'b1;
                nxt.seek_phase = PH_DONE;
            end
        end
    end

    // midpoint of the recorded stops, truncated toward zero
    always_comb
    begin
        sum = {nxt.max_position[POS_W-1], nxt.max_position}
              + {nxt.min_position[POS_W-1], nxt.min_position};
        sum_adj = sum + {{POS_W{1'b0}}, sum[POS_W]};
        mid = sum_adj[POS_W:1];
        v_max = mid;
    end

    // distance to the midpoint
    always_comb
    begin
        diff = {item.encoder_position[POS_W-1], item.encoder_position}
               - {mid[POS_W-1], mid};
        abs_diff = diff[POS_W] ? (~diff + 1'b1) : diff;
    end

    // pack the commands into the result list in issue order, window test
    always_comb
    begin
        res.at_center = nxt.min_found && nxt.max_found
                        && (abs_diff < {{(POS_W+1-WIN_W){1'b0}}, cfg.center_window});
        res.center_position = (nxt.min_found && nxt.max_found) ? mid : '0;
        n_cmd = 2'({1'b0, f_sample} + {1'b0, f_min} + {1'b0, f_max});
        res.has_command = (n_cmd != 2'd0);
        res.last_index = (n_cmd == 2'd0) ? '0 : RIDX_W'(n_cmd - 2'd1);
        if (f_sample)
            res.targets[0] = v_sample;
        else if (f_min)
            res.targets[0] = v_min;
        else if (f_max)
            res.targets[0] = v_max;
        else
            res.targets[0] = '0;
        res.targets[1] = (f_sample && f_min) ? v_min : v_max;
        res.targets[2] = v_max;
    end

endmodule
